// ----- src/sbd_pkg.sv -----
// Shared constants and types for the subpixel box downscaler.
package sbd_pkg;

    localparam int DEF_MAX_WIDTH    = 2048;
    localparam int DEF_MAX_CHANNELS = 4;
    localparam int DEF_MAX_SUB      = 16;

    localparam int SAMPLE_W = 8;
    localparam int PIX_W    = 8;
    localparam int SUM_W    = 16;
    localparam int ROW_W    = 16;

    localparam int OUT_WIDTH_W  = 12;
    localparam int OUT_HEIGHT_W = 16;
    localparam int CHAN_CNT_W   = 3;
    localparam int SUB_CFG_W    = 5;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OUT_WIDTH     = 3'd0,
        REG_OUT_HEIGHT    = 3'd1,
        REG_CHANNEL_COUNT = 3'd2,
        REG_X_SUB         = 3'd3,
        REG_Y_SUB         = 3'd4
    } cfg_reg_t;

    // Per-request control decoded from the position counters.
    typedef struct packed {
        logic first;
        logic emit;
        logic image_end;
    } item_ctl_t;

    // Finished block sum handed to the divider.
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             image_end;
    } div_req_t;

endpackage

// ----- src/sbd_seq.sv -----
// Configuration registers and position counters that address the line accumulator.
module sbd_seq #(
    parameter int MAX_WIDTH    = sbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = sbd_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_SUB      = sbd_pkg::DEF_MAX_SUB,
    parameter int ADDR_W       = 13,
    parameter int DIV_W        = 9
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [sbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sbd_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           step,
    output logic [ADDR_W-1:0]              addr,
    output sbd_pkg::item_ctl_t             ctl,
    output logic [DIV_W-1:0]               divisor
);

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SUB_W  = (MAX_SUB > 1) ? $clog2(MAX_SUB) : 1;
    localparam int PROD_W = 2 * SUB_W + 2;
    localparam int ROW_W  = sbd_pkg::ROW_W;

    logic [sbd_pkg::OUT_WIDTH_W-1:0]  out_width_reg;
    logic [sbd_pkg::OUT_HEIGHT_W-1:0] out_height_reg;
    logic [sbd_pkg::CHAN_CNT_W-1:0]   channel_count_reg;
    logic [sbd_pkg::SUB_CFG_W-1:0]    x_sub_reg;
    logic [sbd_pkg::SUB_CFG_W-1:0]    y_sub_reg;
    logic [DIV_W-1:0]                 div_reg;

    logic [CH_W-1:0]  chan_pos_reg, chan_next;
    logic [SUB_W-1:0] xsub_pos_reg, xsub_next;
    logic [COL_W-1:0] col_pos_reg, col_next;
    logic [SUB_W-1:0] ysub_pos_reg, ysub_next;
    logic [ROW_W-1:0] row_pos_reg, row_next;

    logic [CH_W-1:0]   chan_last;
    logic [SUB_W-1:0]  xsub_last;
    logic [COL_W-1:0]  col_last;
    logic [SUB_W-1:0]  ysub_last;
    logic [ROW_W-1:0]  row_last;
    logic [SUB_W:0]    xs_cnt, ys_cnt;
    logic [PROD_W-1:0] prod;
    logic              cfg_hit;
    logic              last_chan, last_xs, last_col, last_ys, last_row;

    // A zero register acts as one; values above the build limits saturate.
    always_comb begin
        if (out_width_reg == '0) begin
            col_last = '0;
        end else if (32'(out_width_reg) > MAX_WIDTH) begin
            col_last = COL_W'(MAX_WIDTH - 1);
        end else begin
            col_last = COL_W'(out_width_reg - 1'b1);
        end
        if (channel_count_reg == '0) begin
            chan_last = '0;
        end else if (32'(channel_count_reg) > MAX_CHANNELS) begin
            chan_last = CH_W'(MAX_CHANNELS - 1);
        end else begin
            chan_last = CH_W'(channel_count_reg - 1'b1);
        end
        if (x_sub_reg == '0) begin
            xsub_last = '0;
        end else if (32'(x_sub_reg) > MAX_SUB) begin
            xsub_last = SUB_W'(MAX_SUB - 1);
        end else begin
            xsub_last = SUB_W'(x_sub_reg - 1'b1);
        end
        if (y_sub_reg == '0) begin
            ysub_last = '0;
        end else if (32'(y_sub_reg) > MAX_SUB) begin
            ysub_last = SUB_W'(MAX_SUB - 1);
        end else begin
            ysub_last = SUB_W'(y_sub_reg - 1'b1);
        end
        if (out_height_reg == '0) begin
            row_last = '0;
        end else begin
            row_last = ROW_W'(out_height_reg - 1'b1);
        end
        xs_cnt = {1'b0, xsub_last} + 1'b1;
        ys_cnt = {1'b0, ysub_last} + 1'b1;
        prod   = PROD_W'(xs_cnt) * PROD_W'(ys_cnt);
    end

    always_comb begin
        case (cfg_index)
            sbd_pkg::REG_OUT_WIDTH,
            sbd_pkg::REG_OUT_HEIGHT,
            sbd_pkg::REG_CHANNEL_COUNT,
            sbd_pkg::REG_X_SUB,
            sbd_pkg::REG_Y_SUB: cfg_hit = cfg_wr_en;
            default:            cfg_hit = 1'b0;
        endcase
    end

    assign last_chan = (chan_pos_reg == chan_last);
    assign last_xs   = (xsub_pos_reg == xsub_last);
    assign last_col  = (col_pos_reg == col_last);
    assign last_ys   = (ysub_pos_reg == ysub_last);
    assign last_row  = (row_pos_reg == row_last);

    // The first request of a pixel channel in a subpixel row band finds its entry
    // empty, so the stored word is not consulted then.
    assign ctl.first     = (ysub_pos_reg == '0) && (xsub_pos_reg == '0);
    assign ctl.emit      = last_ys && last_xs;
    assign ctl.image_end = last_chan && last_col && last_row;
    assign addr          = ADDR_W'(col_pos_reg * MAX_CHANNELS + chan_pos_reg);
    assign divisor       = div_reg;

    always_comb begin
        chan_next = chan_pos_reg;
        xsub_next = xsub_pos_reg;
        col_next  = col_pos_reg;
        ysub_next = ysub_pos_reg;
        row_next  = row_pos_reg;
        if (cfg_hit) begin
            chan_next = '0;
            xsub_next = '0;
            col_next  = '0;
            ysub_next = '0;
            row_next  = '0;
        end else if (step) begin
            if (!last_chan) begin
                chan_next = chan_pos_reg + 1'b1;
            end else begin
                chan_next = '0;
                if (!last_xs) begin
                    xsub_next = xsub_pos_reg + 1'b1;
                end else begin
                    xsub_next = '0;
                    if (!last_col) begin
                        col_next = col_pos_reg + 1'b1;
                    end else begin
                        col_next = '0;
                        if (!last_ys) begin
                            ysub_next = ysub_pos_reg + 1'b1;
                        end else begin
                            ysub_next = '0;
                            if (!last_row) begin
                                row_next = row_pos_reg + 1'b1;
                            end else begin
                                row_next = '0;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_width_reg     <= sbd_pkg::OUT_WIDTH_W'(1);
            out_height_reg    <= sbd_pkg::OUT_HEIGHT_W'(1);
            channel_count_reg <= sbd_pkg::CHAN_CNT_W'(1);
            x_sub_reg         <= sbd_pkg::SUB_CFG_W'(1);
            y_sub_reg         <= sbd_pkg::SUB_CFG_W'(1);
            div_reg           <= DIV_W'(1);
            chan_pos_reg      <= '0;
            xsub_pos_reg      <= '0;
            col_pos_reg       <= '0;
            ysub_pos_reg      <= '0;
            row_pos_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    sbd_pkg::REG_OUT_WIDTH:
                        out_width_reg <= cfg_data[sbd_pkg::OUT_WIDTH_W-1:0];
                    sbd_pkg::REG_OUT_HEIGHT:
                        out_height_reg <= cfg_data[sbd_pkg::OUT_HEIGHT_W-1:0];
                    sbd_pkg::REG_CHANNEL_COUNT:
                        channel_count_reg <= cfg_data[sbd_pkg::CHAN_CNT_W-1:0];
                    sbd_pkg::REG_X_SUB:
                        x_sub_reg <= cfg_data[sbd_pkg::SUB_CFG_W-1:0];
                    sbd_pkg::REG_Y_SUB:
                        y_sub_reg <= cfg_data[sbd_pkg::SUB_CFG_W-1:0];
                    default: ;
                endcase
            end
            div_reg      <= DIV_W'(prod);
            chan_pos_reg <= chan_next;
            xsub_pos_reg <= xsub_next;
            col_pos_reg  <= col_next;
            ysub_pos_reg <= ysub_next;
            row_pos_reg  <= row_next;
        end
    end

endmodule

// ----- src/sbd_accum.sv -----
// Line accumulator memory with read-modify-write stage and write-to-read forwarding.
module sbd_accum #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sbd_pkg::SAMPLE_W-1:0]  sample,
    input  logic [ADDR_W-1:0]             addr,
    input  sbd_pkg::item_ctl_t            ctl,
    output logic                          req_valid,
    input  logic                          req_ready,
    output sbd_pkg::div_req_t             req
);

    localparam int SUM_W = sbd_pkg::SUM_W;

    logic [SUM_W-1:0] mem [DEPTH];

    logic                         b_valid_reg;
    sbd_pkg::item_ctl_t           b_ctl_reg;
    logic [ADDR_W-1:0]            b_addr_reg;
    logic [sbd_pkg::SAMPLE_W-1:0] b_sample_reg;
    logic [SUM_W-1:0]             rd_data_reg;
    logic                         fwd_hit_reg;
    logic [SUM_W-1:0]             fwd_data_reg;

    logic             b_move;
    logic             load;
    logic [SUM_W-1:0] base;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] wr_data;

    assign b_move   = b_valid_reg && (!b_ctl_reg.emit || req_ready);
    assign in_ready = !b_valid_reg || b_move;
    assign load     = in_valid && in_ready;

    always_comb begin
        if (b_ctl_reg.first) begin
            base = '0;
        end else if (fwd_hit_reg) begin
            base = fwd_data_reg;
        end else begin
            base = rd_data_reg;
        end
        sum     = base + SUM_W'(b_sample_reg);
        wr_data = b_ctl_reg.emit ? '0 : sum;
    end

    assign req_valid     = b_valid_reg && b_ctl_reg.emit;
    assign req.sum       = sum;
    assign req.image_end = b_ctl_reg.image_end;

    always_ff @(posedge aclk) begin
        if (b_move) begin
            mem[b_addr_reg] <= wr_data;
        end
        if (load) begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            b_ctl_reg    <= ctl;
            b_addr_reg   <= addr;
            b_sample_reg <= sample;
            fwd_hit_reg  <= b_move && (b_addr_reg == addr);
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (in_ready) begin
            b_valid_reg <= in_valid;
        end
    end

endmodule

// ----- src/sbd_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, last stage drives the output.
module sbd_div #(
    parameter int DIV_W = 9
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  sbd_pkg::div_req_t          req,
    input  logic [DIV_W-1:0]           divisor,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [sbd_pkg::PIX_W-1:0]  m_pixel_value,
    output logic                       m_image_end
);

    localparam int SUM_W  = sbd_pkg::SUM_W;
    localparam int PIX_W  = sbd_pkg::PIX_W;
    localparam int STAGES = PIX_W;
    localparam int CMP_W  = SUM_W + DIV_W;

    typedef struct packed {
        logic [SUM_W-1:0] rem;
        logic [PIX_W-1:0] quo;
    } step_t;

    function automatic step_t div_step(logic [SUM_W-1:0] rem, logic [PIX_W-1:0] quo,
                                       logic [DIV_W-1:0] d, int shift);
        logic [CMP_W-1:0] cmp;
        step_t            r;
        cmp   = CMP_W'(d) << shift;
        r.rem = rem;
        r.quo = quo;
        if (CMP_W'(rem) >= cmp) begin
            r.rem = rem - SUM_W'(cmp);
            r.quo = quo | (PIX_W'(1) << shift);
        end
        return r;
    endfunction

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_next;
    logic [STAGES-1:0] adv;
    logic [STAGES-1:0] in_v;
    logic [STAGES-1:0] in_end;
    logic [STAGES-1:0] end_reg;
    logic [SUM_W-1:0]  in_rem  [STAGES];
    logic [PIX_W-1:0]  in_quo  [STAGES];
    step_t             res     [STAGES];
    logic [SUM_W-1:0]  rem_reg [STAGES];
    logic [PIX_W-1:0]  quo_reg [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        if (k == 0) begin : g_head
            assign in_v[k]   = req_valid;
            assign in_rem[k] = req.sum;
            assign in_quo[k] = '0;
            assign in_end[k] = req.image_end;
        end else begin : g_body
            assign in_v[k]   = v_reg[k-1];
            assign in_rem[k] = rem_reg[k-1];
            assign in_quo[k] = quo_reg[k-1];
            assign in_end[k] = end_reg[k-1];
        end
        if (k == STAGES - 1) begin : g_tail
            assign adv[k] = !v_reg[k] || m_ready;
        end else begin : g_chain
            assign adv[k] = !v_reg[k] || adv[k+1];
        end
        assign res[k]    = div_step(in_rem[k], in_quo[k], divisor, STAGES - 1 - k);
        assign v_next[k] = adv[k] ? in_v[k] : v_reg[k];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < STAGES; k++) begin
            if (adv[k] && in_v[k]) begin
                rem_reg[k] <= res[k].rem;
                quo_reg[k] <= res[k].quo;
                end_reg[k] <= in_end[k];
            end
        end
    end

    assign req_ready     = adv[0];
    assign m_valid       = v_reg[STAGES-1];
    assign m_pixel_value = quo_reg[STAGES-1];
    assign m_image_end   = end_reg[STAGES-1];

endmodule

// ----- src/subpixel_box_downscale_core.sv -----
// Throughput: one sample request per cycle unless the divider holds back a finished sum;
// the accumulator memory is read as a request is accepted and written back as the request
// leaves the accumulator stage, and the eight-stage divider takes one quotient bit per stage.
// Reset (aresetn, synchronous, active low) sets all registers to 1, zeroes the counters
// and empties the pipeline; the line memory is not swept, because the first request of
// each pixel channel in a subpixel row band treats its entry as zero.
module subpixel_box_downscale_core #(
    parameter int MAX_WIDTH    = sbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = sbd_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_SUB      = sbd_pkg::DEF_MAX_SUB
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port.
    input  logic                          cfg_wr_en,
    input  logic [sbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sbd_pkg::CFG_W-1:0]     cfg_data,
    // Sample requests.
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sbd_pkg::SAMPLE_W-1:0]  s_sample,
    // Averaged pixel bytes.
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sbd_pkg::PIX_W-1:0]     m_pixel_value,
    output logic                          m_image_end
);

    // The line memory holds one 16-bit running sum per output column and channel.
    localparam int DEPTH  = MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // The divisor x_sub*y_sub needs enough bits for MAX_SUB squared.
    localparam int DIV_W  = $clog2(MAX_SUB * MAX_SUB + 1);

    logic                s_accept;
    logic [ADDR_W-1:0]   seq_addr;
    sbd_pkg::item_ctl_t  seq_ctl;
    logic [DIV_W-1:0]    divisor;
    logic                acc_req_valid;
    logic                acc_req_ready;
    sbd_pkg::div_req_t   acc_req;

    assign s_accept = s_valid && s_ready;

    // The sequencer walks row, subpixel row, column, subpixel column and channel, and tells
    // the accumulator where each sample goes and whether it closes a pixel channel.
    // Any write to a defined register restarts the image from the first position.
    sbd_seq #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_SUB      (MAX_SUB),
        .ADDR_W       (ADDR_W),
        .DIV_W        (DIV_W)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (s_accept),
        .addr      (seq_addr),
        .ctl       (seq_ctl),
        .divisor   (divisor)
    );

    // The accumulator reads the entry as the request is accepted, adds the sample in the
    // following cycle and writes the sum back, or zero when the pixel channel is complete.
    // Back-to-back requests to one entry are covered by forwarding the written value.
    sbd_accum #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .sample    (s_sample),
        .addr      (seq_addr),
        .ctl       (seq_ctl),
        .req_valid (acc_req_valid),
        .req_ready (acc_req_ready),
        .req       (acc_req)
    );

    // Completed sums are divided by x_sub*y_sub with a truncated quotient. Each stage
    // moves on whenever the stage after it is empty or moving, so bubbles collapse and
    // a result held at the output does not stop the stages behind it from filling.
    sbd_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .req_valid     (acc_req_valid),
        .req_ready     (acc_req_ready),
        .req           (acc_req),
        .divisor       (divisor),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_value (m_pixel_value),
        .m_image_end   (m_image_end)
    );

`ifndef SYNTHESIS
    // A register write puts the sequencer back at the start of a subpixel row band.
    a_cfg_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wr_en && (cfg_index <= sbd_pkg::REG_Y_SUB)) |=> seq_ctl.first)
        else $error("register write did not restart the position counters");

    // With the output register empty the whole pipeline must have room for a request.
    a_no_idle_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("sample request refused while the output is empty");

    // A new request may only enter when the accumulator stage is not held by the divider.
    a_hold_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |-> !(acc_req_valid && !acc_req_ready))
        else $error("request accepted over a stalled accumulator stage");
`endif

endmodule

// ----- tb/sv/subpixel_box_downscale_core_tb.sv -----
// Self-checking testbench for the subpixel box downscaler core.
module subpixel_box_downscale_core_tb;
    import sbd_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 12;
    // Idle time after the owed bytes are back, covering requests in flight that produce no result.
    localparam int SETTLE_CYCLES = 16;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int RANDOM_ITEMS  = 450;
    localparam int WIDE_ITEMS    = 320;
    localparam int TALL_ITEMS    = 64;
    localparam int IDLE_PERCENT  = 31;
    localparam int PRINT_CAP     = 200;
    localparam int SUM_DEPTH     = DEF_MAX_WIDTH * DEF_MAX_CHANNELS;
    localparam int unsigned HEIGHT_LIMIT = (1 << OUT_HEIGHT_W) - 1;

    // Register indexes past the last defined register; writes there must be ignored.
    localparam int unsigned FIRST_UNUSED_REG = REG_Y_SUB + 1;
    localparam int unsigned LAST_UNUSED_REG  = (1 << CFG_IDX_W) - 1;

    typedef struct {
        bit [PIX_W-1:0] value;
        bit             image_end;
    } pixel_byte_t;

    // Tracks the register settings, the line accumulator and the position counters,
    // and keeps the averaged bytes the core still owes us, oldest first.
    class box_average_tracker;
        bit [OUT_WIDTH_W-1:0]  width_reg;
        bit [OUT_HEIGHT_W-1:0] height_reg;
        bit [CHAN_CNT_W-1:0]   chan_reg;
        bit [SUB_CFG_W-1:0]    xsub_reg;
        bit [SUB_CFG_W-1:0]    ysub_reg;
        bit [SUM_W-1:0]        line_sums [SUM_DEPTH];
        int unsigned           chan_pos, xsub_pos, col_pos, ysub_pos, row_pos;
        pixel_byte_t           pending_pixels[$];
        int                    mismatch_count;

        function new();
            width_reg      = 1;
            height_reg     = 1;
            chan_reg       = 1;
            xsub_reg       = 1;
            ysub_reg       = 1;
            mismatch_count = 0;
            restart_image();
        endfunction

        function void restart_image();
            foreach (line_sums[i]) line_sums[i] = '0;
            chan_pos = 0;
            xsub_pos = 0;
            col_pos  = 0;
            ysub_pos = 0;
            row_pos  = 0;
        endfunction

        // Zero behaves as one, and anything above the supported maximum saturates.
        function int unsigned clamp_setting(int unsigned v, int unsigned hi);
            if (v == 0) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function void apply_register(bit [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] data);
            case (idx)
                REG_OUT_WIDTH:     width_reg  = data[OUT_WIDTH_W-1:0];
                REG_OUT_HEIGHT:    height_reg = data[OUT_HEIGHT_W-1:0];
                REG_CHANNEL_COUNT: chan_reg   = data[CHAN_CNT_W-1:0];
                REG_X_SUB:         xsub_reg   = data[SUB_CFG_W-1:0];
                REG_Y_SUB:         ysub_reg   = data[SUB_CFG_W-1:0];
                default:           return;
            endcase
            // Any accepted write starts a fresh image.
            restart_image();
        endfunction

        function void note_sample(bit [SAMPLE_W-1:0] smp);
            int unsigned    w, h, ch, xs, ys, entry, quotient;
            bit [SUM_W-1:0] sum;
            bit             last_chan, last_xs, last_col, last_ys, last_row;
            pixel_byte_t    px;
            w  = clamp_setting(width_reg, DEF_MAX_WIDTH);
            h  = clamp_setting(height_reg, HEIGHT_LIMIT);
            ch = clamp_setting(chan_reg, DEF_MAX_CHANNELS);
            xs = clamp_setting(xsub_reg, DEF_MAX_SUB);
            ys = clamp_setting(ysub_reg, DEF_MAX_SUB);
            entry = col_pos * DEF_MAX_CHANNELS + chan_pos;
            if (entry >= SUM_DEPTH) entry = 0;
            last_chan = chan_pos >= ch - 1;
            last_xs   = xsub_pos >= xs - 1;
            last_col  = col_pos >= w - 1;
            last_ys   = ysub_pos >= ys - 1;
            last_row  = row_pos >= h - 1;
            sum = line_sums[entry] + smp;
            if (last_ys && last_xs) begin
                quotient     = sum / (xs * ys);
                px.value     = quotient[PIX_W-1:0];
                px.image_end = last_chan && last_col && last_row;
                pending_pixels.push_back(px);
                line_sums[entry] = '0;
            end else begin
                line_sums[entry] = sum;
            end
            // Advance channel, then subpixel column, column, subpixel row and row.
            if (!last_chan) begin
                chan_pos++;
            end else begin
                chan_pos = 0;
                if (!last_xs) begin
                    xsub_pos++;
                end else begin
                    xsub_pos = 0;
                    if (!last_col) begin
                        col_pos++;
                    end else begin
                        col_pos = 0;
                        if (!last_ys) begin
                            ysub_pos++;
                        end else begin
                            ysub_pos = 0;
                            if (!last_row) row_pos++;
                            else row_pos = 0;
                        end
                    end
                end
            end
        endfunction

        task report_mismatch(string msg);
            // A broken core would flood the log, so only the first PRINT_CAP are printed.
            if (mismatch_count < PRINT_CAP) $display("MISMATCH at %0t: %s", $time, msg);
            mismatch_count++;
        endtask

        task check_pixel(logic [PIX_W-1:0] value, logic image_end);
            pixel_byte_t want;
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("pixel byte %0d image_end %0b with none expected",
                                          value, image_end));
                return;
            end
            want = pending_pixels.pop_front();
            if (value !== want.value)
                report_mismatch($sformatf("pixel_value %0d, expected %0d", value, want.value));
            if (image_end !== want.image_end)
                report_mismatch($sformatf("image_end %0b, expected %0b",
                                          image_end, want.image_end));
        endtask

        task finish_check();
            if (pending_pixels.size() != 0)
                report_mismatch($sformatf("%0d pixel bytes never arrived",
                                          pending_pixels.size()));
        endtask
    endclass

    // Every input of the core has a known value from time zero.
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [SAMPLE_W-1:0]  s_sample  = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [PIX_W-1:0]     m_pixel_value;
    logic                 m_image_end;

    // When set, neither the sample sender nor the pixel receiver ever idles.
    bit no_idle = 1'b0;

    box_average_tracker board;

    subpixel_box_downscale_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_value (m_pixel_value),
        .m_image_end   (m_image_end)
    );

    always #CLK_HALF aclk = ~aclk;

    // Receiver side: stall at random and check every pixel byte that is taken.
    // Values read here are the ones present at the edge, since everything the
    // testbench and the core drive changes through nonblocking updates.
    always @(posedge aclk) begin
        m_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
        if (aresetn && m_valid && m_ready) board.check_pixel(m_pixel_value, m_image_end);
    end

    // Mostly uniform bytes, with the two extremes favored.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int unsigned         r;
        logic [SAMPLE_W-1:0] v;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        v = SAMPLE_W'($urandom_range(255));
        return v;
    endfunction

    // Offers one sample request, holding it until the core takes it. Random idle
    // cycles go in front of the request.
    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_sample(value);
    endtask

    // One write strobe, lowered again before the task returns, so back-to-back calls never
    // lower and raise the strobe at the same edge.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        board.apply_register(idx, data);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Stops offering samples until every owed pixel byte has come back.
    task automatic wait_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending_pixels.size() != 0) @(posedge aclk);
    endtask

    // Makes the core fully idle, including requests that owe no result.
    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes all five registers; the bits above each register's width carry noise
    // that the core must drop.
    task automatic configure(input int unsigned w, h, ch, xs, ys);
        logic [CFG_W-1:0] noise;
        noise = CFG_W'($urandom_range(0, 65535));
        write_register(REG_OUT_WIDTH,     {noise[CFG_W-1:OUT_WIDTH_W], w[OUT_WIDTH_W-1:0]});
        write_register(REG_OUT_HEIGHT,    h[OUT_HEIGHT_W-1:0]);
        write_register(REG_CHANNEL_COUNT, {noise[CFG_W-1:CHAN_CNT_W], ch[CHAN_CNT_W-1:0]});
        write_register(REG_X_SUB,         {noise[CFG_W-1:SUB_CFG_W], xs[SUB_CFG_W-1:0]});
        write_register(REG_Y_SUB,         {~noise[CFG_W-1:SUB_CFG_W], ys[SUB_CFG_W-1:0]});
    endtask

    // One random setting and a run of samples. Small images are sent whole, one or
    // two times, often with a partial tail that the next register write throws away.
    // Some phases pause mid-run until the core has drained, and some also write an
    // unused register index there, which must leave the image in progress alone.
    task automatic run_random_phase(inout int unsigned sent_total,
                                    input int unsigned phase_no);
        int unsigned       w, h, ch, xs, ys, n, half, i, img;
        longint unsigned   per_image;
        w  = ($urandom_range(9) == 0) ? $urandom_range(0, 4095) : $urandom_range(1, 6);
        h  = ($urandom_range(9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3);
        ch = $urandom_range(0, 7);
        xs = ($urandom_range(9) < 2) ? $urandom_range(0, 31) : $urandom_range(0, 4);
        ys = ($urandom_range(9) < 2) ? $urandom_range(0, 31) : $urandom_range(0, 4);
        configure(w, h, ch, xs, ys);
        per_image = longint'(board.clamp_setting(w, DEF_MAX_WIDTH))
                  * board.clamp_setting(h, HEIGHT_LIMIT)
                  * board.clamp_setting(ch, DEF_MAX_CHANNELS)
                  * board.clamp_setting(xs, DEF_MAX_SUB)
                  * board.clamp_setting(ys, DEF_MAX_SUB);
        if (per_image <= 120) begin
            img = 32'(per_image);
            n = img * $urandom_range(1, 2) + $urandom_range(0, img / 2);
        end else begin
            n = $urandom_range(40, 160);
        end
        half = n / 2;
        for (i = 0; i < n; i++) begin
            if (i == half && phase_no % 4 == 1) begin
                wait_results();
            end else if (i == half && phase_no % 4 == 3) begin
                settle();
                write_register(CFG_IDX_W'($urandom_range(FIRST_UNUSED_REG, LAST_UNUSED_REG)),
                               CFG_W'($urandom_range(0, 65535)));
            end
            send_sample(pick_sample());
        end
        sent_total += n;
    endtask

    initial begin
        int unsigned random_sent;
        int unsigned phase_no;
        board       = new();
        random_sent = 0;
        phase_no    = 0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings are all ones: every sample is its own one-pixel image,
        // so each byte comes straight back with image_end set.
        send_sample(8'h00);
        send_sample(8'hFF);
        send_sample(8'h55);
        send_sample(8'hAA);
        send_sample(8'h01);
        send_sample(8'h80);

        // Registers written as zero must act as one.
        settle();
        configure(0, 0, 0, 0, 0);
        send_sample(8'h80);
        send_sample(8'h7F);

        // Two pixels of two horizontal subpixels each. Writes to unused indexes in
        // the middle of a pixel must not disturb it.
        settle();
        configure(2, 1, 1, 2, 1);
        send_sample(8'hFF);
        settle();
        for (int unsigned idx = FIRST_UNUSED_REG; idx <= LAST_UNUSED_REG; idx++)
            write_register(CFG_IDX_W'(idx), CFG_W'($urandom_range(0, 65535)));
        send_sample(8'hFF);
        send_sample(8'd10);

        // A real write in the middle of a pixel drops the partial sum and restarts
        // the image; the last lines run past the image end into a new image.
        settle();
        write_register(REG_X_SUB, CFG_W'(2));
        send_sample(8'd20);
        send_sample(8'd30);
        send_sample(8'd40);
        send_sample(8'd51);
        send_sample(8'd3);
        send_sample(8'd4);

        // An oversized width along a long line, sent with no idling on either side
        // so the core runs at full rate for a long stretch.
        settle();
        configure(4095, 1, 1, 1, 1);
        no_idle <= 1'b1;
        repeat (WIDE_ITEMS) send_sample(pick_sample());
        settle();
        no_idle <= 1'b0;

        // Largest block: oversized x_sub saturates at 16 by 16. The pixel is all
        // full-scale bytes, which gives the largest sum a block can reach.
        settle();
        configure(1, 2, 1, 31, 16);
        repeat (DEF_MAX_SUB * DEF_MAX_SUB) send_sample(8'hFF);

        // Tallest image with the channel count saturating at four: image_end never rises.
        settle();
        configure(3, 65535, 7, 2, 1);
        repeat (TALL_ITEMS) send_sample(pick_sample());

        while (random_sent < RANDOM_ITEMS) begin
            settle();
            run_random_phase(random_sent, phase_no);
            phase_no++;
        end

        settle();
        board.finish_check();
        if (board.mismatch_count == 0) begin
            $display("subpixel_box_downscale_core test passed");
        end else begin
            $display("subpixel_box_downscale_core test failed");
        end
        $finish;
    end

    // Hard stop in case the core hangs on either handshake.
    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("subpixel_box_downscale_core test failed");
        $finish;
    end

endmodule
